### rtl/lzss_pkg.sv
// package for the lzss ring window decoder
// transaction types, decode phase and controller enums, control structs
`timescale 1ns / 1ps

package lzss_pkg;

  localparam int unsigned CFG_W         = 16;
  localparam logic [15:0] OUT_LEN_RESET = 16'd32000;
  localparam logic [15:0] COPY_BASE     = 16'd66;
  localparam logic [6:0]  LEN_BIAS      = 7'd3;
  localparam logic [3:0]  FLAG_COUNT    = 4'd8;
  localparam logic [1:0]  PAIR_ONE      = 2'd1;
  localparam logic [1:0]  PAIR_TWO      = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_a;
    logic [7:0] pixel_b;
    logic [1:0] pair_count;
    logic       last_of_run;
    logic       image_done;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_UNIT  = 2'd1,
    PH_TOKEN = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_COPY = 1'b1
  } state_e;

  typedef struct packed {
    logic take_item;
    logic copy_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic token_go;
    logic copy_push;
    logic copy_end;
  } status_t;

endpackage

### rtl/lzss_ctrl.sv
// controller state machine: input handshake and copy sequencing
// depends on lzss_pkg
`timescale 1ns / 1ps

module lzss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lzss_pkg::status_t status_i,
  output lzss_pkg::cmd_t    cmd_o
);
  import lzss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take_item && status_i.token_go) begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        if (cmd_o.copy_emit && status_i.copy_end) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = status_i.out_free;
        cmd_o.take_item = in_valid_i && status_i.out_free;
      end
      ST_COPY: begin
        cmd_o.copy_emit   = !status_i.copy_push || status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY |-> !in_ready_o)
    else $error("input taken during copy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take_item && status_i.token_go |=> state_q == ST_COPY)
    else $error("copy token did not start a copy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.copy_emit && status_i.copy_push |-> status_i.out_free)
    else $error("copy result pushed into a full output register");

endmodule

### rtl/lzss_dp.sv
// datapath: decode state, ring memory, copy address and pair packing
// depends on lzss_pkg; driven by lzss_ctrl
`timescale 1ns / 1ps

module lzss_dp #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lzss_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lzss_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [lzss_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  lzss_pkg::cmd_t              cmd_i,
  output lzss_pkg::status_t           status_o
);
  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);

  // stream state
  phase_e           phase_q, phase_d;
  logic [7:0]       flag_bits_q, flag_bits_d;
  logic [3:0]       flags_left_q, flags_left_d;
  logic [7:0]       token_first_q, token_first_d;
  logic [CFG_W-1:0] pos_q, pos_d;
  logic             finished_q, finished_d;
  logic [CFG_W-1:0] length_q;

  // copy state
  logic [AW-1:0]    src_q, src_d;
  logic [6:0]       remain_q, remain_d;
  logic             half_q, half_d;
  logic [7:0]       half_data_q, half_data_d;

  // output register
  logic             out_valid_q;
  out_item_t        out_q, out_d;
  logic             push;

  // ring memory
  logic [7:0]       ring_q [RING_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    waddr, raddr;
  logic [7:0]       wdata;
  logic [7:0]       rdata_q, byp_data_q;
  logic             byp_q, hit_q;
  logic [CFG_W-1:0] pos_base;

  // effective state for an incoming transaction
  logic             first;
  phase_e           phase_eff;
  logic [7:0]       flag_bits_eff, token_first_eff;
  logic [3:0]       flags_left_eff, fl_next;
  logic [CFG_W-1:0] pos_eff, pos_eff_inc, pos_q_inc;
  logic             ignore;
  logic [CFG_W-1:0] src_start;
  logic [7:0]       copy_byte;
  logic             copy_done;

  assign first           = in_data_i.first_byte;
  assign phase_eff       = first ? PH_FLAG : phase_q;
  assign flag_bits_eff   = first ? 8'd0 : flag_bits_q;
  assign flags_left_eff  = first ? 4'd0 : flags_left_q;
  assign token_first_eff = first ? 8'd0 : token_first_q;
  assign pos_eff         = first ? '0 : pos_q;
  assign pos_eff_inc     = pos_eff + 1'b1;
  assign pos_q_inc       = pos_q + 1'b1;
  assign ignore          = (!first && finished_q) || (pos_eff >= length_q);
  assign fl_next         = flags_left_eff - ((flags_left_eff != 4'd0) ? 4'd1 : 4'd0);
  assign src_start       = COPY_BASE + {6'd0, token_first_eff[1:0], in_data_i.data_byte};

  assign copy_byte = byp_q ? byp_data_q : (hit_q ? rdata_q : 8'd0);
  assign copy_done = pos_q_inc >= length_q;

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.token_go  = !ignore && (phase_eff == PH_TOKEN);
  assign status_o.copy_end  = (remain_q == 7'd1) || copy_done;
  assign status_o.copy_push = half_q || status_o.copy_end;

  always_comb begin
    phase_d       = phase_q;
    flag_bits_d   = flag_bits_q;
    flags_left_d  = flags_left_q;
    token_first_d = token_first_q;
    pos_d         = pos_q;
    finished_d    = finished_q;
    src_d         = src_q;
    remain_d      = remain_q;
    half_d        = half_q;
    half_data_d   = half_data_q;
    out_d         = out_q;
    push          = 1'b0;
    mem_we        = 1'b0;
    waddr         = pos_q[AW-1:0];
    wdata         = copy_byte;
    raddr         = src_q;
    pos_base      = pos_q;

    if (cmd_i.take_item) begin
      pos_base      = pos_eff;
      phase_d       = phase_eff;
      flag_bits_d   = flag_bits_eff;
      flags_left_d  = flags_left_eff;
      token_first_d = token_first_eff;
      pos_d         = pos_eff;
      finished_d    = first ? 1'b0 : finished_q;
      if (ignore) begin
        finished_d = 1'b1;
      end else begin
        case (phase_eff)
          PH_UNIT: begin
            flag_bits_d  = {1'b0, flag_bits_eff[7:1]};
            flags_left_d = fl_next;
            if (flag_bits_eff[0]) begin
              // literal
              mem_we            = 1'b1;
              waddr             = pos_eff[AW-1:0];
              wdata             = in_data_i.data_byte;
              pos_d             = pos_eff_inc;
              finished_d        = pos_eff_inc >= length_q;
              push              = 1'b1;
              out_d.pixel_a     = in_data_i.data_byte;
              out_d.pixel_b     = 8'd0;
              out_d.pair_count  = PAIR_ONE;
              out_d.last_of_run = 1'b1;
              out_d.image_done  = pos_eff_inc >= length_q;
              phase_d           = (fl_next == 4'd0) ? PH_FLAG : PH_UNIT;
            end else begin
              token_first_d = in_data_i.data_byte;
              phase_d       = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            raddr    = src_start[AW-1:0];
            src_d    = src_start[AW-1:0];
            remain_d = {1'b0, token_first_eff[7:2]} + LEN_BIAS;
            half_d   = 1'b0;
            phase_d  = (flags_left_eff == 4'd0) ? PH_FLAG : PH_UNIT;
          end
          default: begin
            flag_bits_d  = in_data_i.data_byte;
            flags_left_d = FLAG_COUNT;
            phase_d      = PH_UNIT;
          end
        endcase
      end
    end else if (cmd_i.copy_emit) begin
      mem_we   = 1'b1;
      waddr    = pos_q[AW-1:0];
      wdata    = copy_byte;
      pos_d    = pos_q_inc;
      remain_d = remain_q - 7'd1;
      src_d    = src_q + 1'b1;
      raddr    = src_q + 1'b1;
      if (status_o.copy_end) begin
        finished_d = copy_done;
      end
      if (half_q) begin
        push              = 1'b1;
        half_d            = 1'b0;
        out_d.pixel_a     = half_data_q;
        out_d.pixel_b     = copy_byte;
        out_d.pair_count  = PAIR_TWO;
        out_d.last_of_run = status_o.copy_end;
        out_d.image_done  = status_o.copy_end && copy_done;
      end else if (status_o.copy_end) begin
        push              = 1'b1;
        out_d.pixel_a     = copy_byte;
        out_d.pixel_b     = 8'd0;
        out_d.pair_count  = PAIR_ONE;
        out_d.last_of_run = 1'b1;
        out_d.image_done  = copy_done;
      end else begin
        half_d      = 1'b1;
        half_data_d = copy_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_FLAG;
      flag_bits_q   <= '0;
      flags_left_q  <= '0;
      token_first_q <= '0;
      pos_q         <= '0;
      finished_q    <= 1'b0;
      length_q      <= OUT_LEN_RESET;
      remain_q      <= '0;
      half_q        <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      flag_bits_q   <= flag_bits_d;
      flags_left_q  <= flags_left_d;
      token_first_q <= token_first_d;
      pos_q         <= pos_d;
      finished_q    <= finished_d;
      remain_q      <= remain_d;
      half_q        <= half_d;
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_d_reg: begin
      src_q       <= src_d;
      half_data_q <= half_data_d;
      out_q       <= out_d;
    end
  end

  // ring memory, registered read with write bypass
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[waddr] <= wdata;
    end
    rdata_q    <= ring_q[raddr];
    byp_q      <= mem_we && (waddr == raddr);
    byp_data_q <= wdata;
    // entry counts as written once the fill position has passed it
    hit_q      <= (pos_base >= CFG_W'(RING_DEPTH)) || ({{(CFG_W-AW){1'b0}}, raddr} < pos_base);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> status_o.out_free)
    else $error("output register overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy_emit |-> (pos_q < length_q) && (remain_q != 7'd0))
    else $error("copy step beyond image or run length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_item |-> !half_q)
    else $error("half pair left over after copy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.copy_emit && status_o.copy_end |=> !half_q)
    else $error("copy ended with unflushed byte");

endmodule

### rtl/lzss_ring_window_decoder.sv
// lzss ring window decoder: a copy token stalls input while its bytes are
// copied, one per cycle unless the output register is full (one ring memory
// read port); results carry 1 or 2 bytes and are held in an output register
// reset: asynchronous active low; clears decode state, position, length to 32000
// the ring memory keeps its contents; a fill count marks written entries
// depends on lzss_pkg, lzss_ctrl, lzss_dp
`timescale 1ns / 1ps

module lzss_ring_window_decoder #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lzss_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lzss_pkg::out_item_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [lzss_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import lzss_pkg::*;

  cmd_t    cmd;
  status_t status;

  lzss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lzss_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
